/* hw/rtl/wavetable_oscillator_lerp_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the wavetable oscillator RTL.
// ----------------------------------------------------------------------------
`ifndef WAVETABLE_OSCILLATOR_LERP_DEFINES_SVH
`define WAVETABLE_OSCILLATOR_LERP_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication, clocked on clk, disabled in reset
`define WTO_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define WTO_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define WTO_ASSERT_NOW(lbl, ante, cons)
`define WTO_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* hw/rtl/wto_pkg.sv */
// ----------------------------------------------------------------------------
// wto_pkg
// Types and constants of the wavetable oscillator.
// ----------------------------------------------------------------------------
package wto_pkg;

  localparam int IDX_W       = 10;
  localparam int TABLE_DEPTH = 1 << IDX_W;
  localparam int FRAC_W      = 16;
  localparam int PHASE_W     = IDX_W + FRAC_W;
  localparam int SAMPLE_W    = 16;
  localparam int PROD_W      = SAMPLE_W + FRAC_W + 2;
  localparam int HALF        = 1 << (FRAC_W - 1);
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = FIFO_PTR_W + 1;

  localparam logic [PHASE_W-1:0] STEP_RESET = PHASE_W'(669567);

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_TICK  = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                       cmd;
    logic [IDX_W-1:0]           idx;
    logic signed [SAMPLE_W-1:0] value;
  } item_t;

endpackage

/* hw/rtl/wto_ram.sv */
// ----------------------------------------------------------------------------
// wto_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module wto_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem_r[raddr_a];
      rdata_b <= mem_r[raddr_b];
    end
  end

endmodule

/* hw/rtl/wto_front.sv */
// ----------------------------------------------------------------------------
// wto_front
// Input side: accepts command words and queues them for the back end.
// ----------------------------------------------------------------------------
`include "wavetable_oscillator_lerp_defines.svh"

module wto_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_command,
  input  logic [wto_pkg::IDX_W-1:0]      in_entry_index,
  input  logic signed [wto_pkg::SAMPLE_W-1:0] in_entry_value,
  output wto_pkg::item_t                 head,
  output logic                           head_valid,
  input  logic                           pop
);

  localparam logic [wto_pkg::FIFO_CNT_W-1:0] CNT_MAX =
    wto_pkg::FIFO_CNT_W'(wto_pkg::FIFO_DEPTH);

  wto_pkg::item_t                      mem_r [wto_pkg::FIFO_DEPTH];
  logic [wto_pkg::FIFO_PTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [wto_pkg::FIFO_PTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [wto_pkg::FIFO_CNT_W-1:0]      count_r, count_nxt;
  logic                                push;
  wto_pkg::item_t                      in_item;

  assign in_stall   = (count_r == CNT_MAX);
  assign push       = in_valid && !in_stall;
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    in_item.cmd   = wto_pkg::cmd_t'(in_command);
    in_item.idx   = in_entry_index;
    in_item.value = in_entry_value;
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + wto_pkg::FIFO_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + wto_pkg::FIFO_PTR_W'(1) : rd_ptr_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + wto_pkg::FIFO_CNT_W'(1);
      2'b01:   count_nxt = count_r - wto_pkg::FIFO_CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

  `WTO_ASSERT_NOW(a_pop_nonempty, pop, count_r != '0)
  `WTO_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_MAX)
  `WTO_ASSERT_NEXT(a_count_inc, push && !pop, count_r == $past(count_r) + 1'b1)

endmodule

/* hw/rtl/wto_back.sv */
// ----------------------------------------------------------------------------
// wto_back
// Execution side: table writes, phase accumulator, interpolation pipeline.
// ----------------------------------------------------------------------------
`include "wavetable_oscillator_lerp_defines.svh"

module wto_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  wto_pkg::item_t                      head,
  input  logic                                head_valid,
  output logic                                pop,
  input  logic                                cfg_valid,
  input  logic [wto_pkg::PHASE_W-1:0]         cfg_phase_step,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [wto_pkg::SAMPLE_W-1:0] out_sample
);

  localparam int IW = wto_pkg::IDX_W;
  localparam int FW = wto_pkg::FRAC_W;
  localparam int SW = wto_pkg::SAMPLE_W;
  localparam int PW = wto_pkg::PROD_W;

  logic [wto_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [wto_pkg::PHASE_W-1:0] step_r, step_nxt;
  logic                        en, issue, tick, wr;
  logic [IW-1:0]               lo, hi;
  logic [SW-1:0]               rdata_a, rdata_b;

  logic                 v1_r, v2_r, v3_r, out_valid_r;
  logic [FW-1:0]        f1_r;
  logic signed [SW-1:0] a2_r;
  logic signed [PW-1:0] prod2_r, prod2_nxt;
  logic signed [PW-1:0] acc3_r, acc3_nxt;
  logic signed [PW-1:0] rnd;
  logic signed [SW-1:0] out_sample_r;
  logic signed [SW:0]   diff;
  logic signed [FW:0]   frac_s;

  assign en    = !out_valid_r || !out_stall;
  assign issue = head_valid && en;
  assign pop   = issue;
  assign tick  = issue && (head.cmd == wto_pkg::CMD_TICK);
  assign wr    = issue && (head.cmd == wto_pkg::CMD_WRITE);
  assign lo    = phase_r[wto_pkg::PHASE_W-1 -: IW];
  assign hi    = lo + IW'(1);

  wto_ram #(
    .WIDTH(SW),
    .DEPTH(wto_pkg::TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .we      (wr),
    .waddr   (head.idx),
    .wdata   (head.value),
    .re      (en),
    .raddr_a (lo),
    .raddr_b (hi),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  always_comb begin
    phase_nxt = tick ? phase_r + step_r : phase_r;
    step_nxt  = cfg_valid ? cfg_phase_step : step_r;
  end

  // a*(1-f) + b*f  ==  a*2^F + (b-a)*f
  always_comb begin
    diff      = $signed({rdata_b[SW-1], rdata_b}) - $signed({rdata_a[SW-1], rdata_a});
    frac_s    = $signed({1'b0, f1_r});
    prod2_nxt = PW'(diff) * PW'(frac_s);
    acc3_nxt  = (PW'(a2_r) <<< FW) + prod2_r;
    // round half away from zero
    rnd       = acc3_r + (acc3_r[PW-1] ? PW'(wto_pkg::HALF - 1) : PW'(wto_pkg::HALF));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      step_r      <= wto_pkg::STEP_RESET;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      step_r  <= step_nxt;
      if (en) begin
        v1_r        <= tick;
        v2_r        <= v1_r;
        v3_r        <= v2_r;
        out_valid_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_r         <= phase_r[FW-1:0];
      a2_r         <= $signed(rdata_a);
      prod2_r      <= prod2_nxt;
      acc3_r       <= acc3_nxt;
      out_sample_r <= rnd[FW +: SW];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

  `WTO_ASSERT_NEXT(a_phase_hold, !tick, phase_r == $past(phase_r))
  `WTO_ASSERT_NEXT(a_phase_adv, tick, phase_r == $past(phase_r + step_r))
  `WTO_ASSERT_NEXT(a_pipe_out, en && v3_r, out_valid_r)

endmodule

/* hw/rtl/wavetable_oscillator_lerp.sv */
// ----------------------------------------------------------------------------
// wavetable_oscillator_lerp
// Table oscillator with 10.16 phase accumulator and linear interpolation.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one command word per accept. Command 0
// stores in_entry_value at in_entry_index and gives no result; command 1
// produces one interpolated sample and advances the phase by the step.
// Output channel (out_valid / out_stall): one out_sample word per tick.
// Config channel (cfg_valid / cfg_ready): writes the phase step; cfg_ready is
// always high, write only while the block is idle.
// Throughput: one command word per cycle while out_stall does not freeze the
// pipeline, set by the phase add and the dual-read table RAM. A tick passes
// the queue, table read, multiply, sum and round registers in that order.
// A four-word queue separates input accept from execution; when out_stall
// holds, the pipeline freezes, the queue fills and in_stall rises.
// Reset clears the phase to zero, loads the default step and empties the
// queue and pipeline. Table contents are undefined until written.
// ----------------------------------------------------------------------------
module wavetable_oscillator_lerp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_command,
  input  logic [wto_pkg::IDX_W-1:0]           in_entry_index,
  input  logic signed [wto_pkg::SAMPLE_W-1:0] in_entry_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [wto_pkg::SAMPLE_W-1:0] out_sample,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wto_pkg::PHASE_W-1:0]         cfg_phase_step
);

  wto_pkg::item_t head;
  logic           head_valid;
  logic           pop;

  assign cfg_ready = 1'b1;

  wto_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_entry_index (in_entry_index),
    .in_entry_value (in_entry_value),
    .head           (head),
    .head_valid     (head_valid),
    .pop            (pop)
  );

  wto_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .head_valid     (head_valid),
    .pop            (pop),
    .cfg_valid      (cfg_valid && cfg_ready),
    .cfg_phase_step (cfg_phase_step),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample     (out_sample)
  );

endmodule
